/* src/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue with erase.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int RSP_CNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_ERASE      = 3'd4,
    OP_CLEAR      = 3'd5
  } op_t;

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic              shr;        // push front: take left neighbor
    logic              shl;        // pop front: take right neighbor
    logic              erase;      // erase search active
    logic              append;     // tail cell loads value
    logic [DATA_W-1:0] value;
  } cell_ctl_t;

  typedef struct packed {
    logic                 ok;
    logic [RSP_CNT_W-1:0] count;
    logic                 empty_res;
  } rsp_t;

endpackage

/* src/deq_if.sv */
// ----------------------------------------------------------------------------
// deq_if
// Request and response channels: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface deq_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic signed [31:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface deq_rsp_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic [4:0] count;
  logic       empty_res;

  modport source (output valid, output ok, output count, output empty_res, input ready);
  modport sink   (input valid, input ok, input count, input empty_res, output ready);
endinterface

/* src/deq_cell.sv */
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the queue row: holds one entry, shifts left or right
// with its neighbors, and takes part in the first-match erase chain.
// ----------------------------------------------------------------------------
module deq_cell
  import deq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDX   = 0,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [CW-1:0]     count,
  input  logic [DATA_W-1:0] left,
  input  logic [DATA_W-1:0] right,
  input  logic              hit_in,
  output logic              hit_out,
  output logic [DATA_W-1:0] data
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic              live;
  logic              is_hit;
  logic [DATA_W-1:0] data_next;

  assign live    = IDX_C < count;
  assign is_hit  = ctl.erase & live & (data == ctl.value);
  // Once a match is seen at or ahead of this cell, this cell closes the gap.
  assign hit_out = hit_in | is_hit;

  always_comb begin
    priority if (ctl.shr) begin
      data_next = left;
    end else if (ctl.shl) begin
      data_next = right;
    end else if (ctl.erase && hit_out) begin
      data_next = right;
    end else if (ctl.append && (count == IDX_C)) begin
      data_next = ctl.value;
    end else begin
      data_next = data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

/* src/deq_rbuf.sv */
// ----------------------------------------------------------------------------
// deq_rbuf
// Two-entry response buffer; decouples the cell row from output stalls.
// ----------------------------------------------------------------------------
module deq_rbuf
  import deq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  rsp_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  logic v0, v1, v0_next, v1_next;
  rsp_t d0, d1, d0_next, d1_next;
  logic push, pop;

  assign in_ready  = !v1;
  assign out_valid = v0;
  assign out_data  = d0;
  assign push      = in_valid & in_ready;
  assign pop       = v0 & out_ready;

  always_comb begin
    v0_next = v0;
    v1_next = v1;
    d0_next = d0;
    d1_next = d1;
    unique case ({push, pop})
      2'b10: begin
        if (!v0) begin
          d0_next = in_data;
          v0_next = 1'b1;
        end else begin
          d1_next = in_data;
          v1_next = 1'b1;
        end
      end
      2'b01: begin
        d0_next = d1;
        v0_next = v1;
        v1_next = 1'b0;
      end
      2'b11: begin
        if (v1) begin
          d0_next = d1;
          d1_next = in_data;
        end else begin
          d0_next = in_data;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      v0 <= v0_next;
      v1 <= v1_next;
    end
  end

  always_ff @(posedge clk) begin
    d0 <= d0_next;
    d1 <= d1_next;
  end

endmodule

/* src/deque_with_erase_first_match_top.sv */
// ----------------------------------------------------------------------------
// deque_with_erase_first_match_top
// Bounded double-ended queue of 32-bit values with erase of first match.
// ----------------------------------------------------------------------------
// The queue is a row of DEPTH cells, front at cell 0, that shift together.
// One request is taken per clock while the response buffer has room; every
// operation, erase included, completes in the cycle it is accepted, and its
// response (ok, count, empty_res) is offered on the response channel once
// the responses ahead of it in the buffer have gone. The cell row shifts as
// a whole, and during an erase the first-match hit chain runs from cell 0 to
// the last cell. A two-entry response buffer keeps requests flowing while a
// response waits; requests stall only when both buffer slots are full. count
// is the entry count truncated to five bits. Entry contents are not reset;
// only positions below the count are ever read.
// ----------------------------------------------------------------------------
module deque_with_erase_first_match_top
  import deq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  deq_req_if.sink   req,
  deq_rsp_if.source rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C  = CW'(1);

  // entry count register
  logic [CW-1:0] count, count_next;

  logic       accept;
  logic       full, empty;
  logic       ok;
  logic       buf_ready;
  cell_ctl_t  ctl;
  rsp_t       rsp_in, rsp_out;

  // cell row wiring; hit[i] is "a match exists ahead of cell i"
  logic [DATA_W-1:0] cdata [DEPTH];
  logic [DEPTH:0]    hit;

  assign req.ready = buf_ready;
  assign accept    = req.valid & buf_ready;
  assign full      = count == FULL_C;
  assign empty     = count == '0;
  assign hit[0]    = 1'b0;

  // Decode the request: success flag and new count.
  always_comb begin
    ok         = 1'b0;
    count_next = count;
    unique case (req.operation)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        ok = !full;
        if (!full) count_next = count + ONE_C;
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        ok = !empty;
        if (!empty) count_next = count - ONE_C;
      end
      OP_ERASE: begin
        ok = hit[DEPTH];
        if (hit[DEPTH]) count_next = count - ONE_C;
      end
      OP_CLEAR: begin
        ok         = !empty;
        count_next = '0;
      end
      default: begin
        // undefined codes: no change, ok low
      end
    endcase
  end

  // Command to the cell row, only on an accepted request; pushes and pop front only when they can succeed.
  always_comb begin
    ctl.value  = DATA_W'(req.value);
    ctl.shr    = accept && (req.operation == OP_PUSH_FRONT) && !full;
    ctl.append = accept && (req.operation == OP_PUSH_BACK) && !full;
    ctl.shl    = accept && (req.operation == OP_POP_FRONT) && !empty;
    ctl.erase  = accept && (req.operation == OP_ERASE);
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [DATA_W-1:0] left_d, right_d;
      if (gi == 0) begin : g_first
        assign left_d = ctl.value;
      end else begin : g_mid
        assign left_d = cdata[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_d = cdata[gi];
      end else begin : g_inner
        assign right_d = cdata[gi+1];
      end

      deq_cell #(
        .DEPTH (DEPTH),
        .IDX   (gi),
        .CW    (CW)
      ) u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .count   (count),
        .left    (left_d),
        .right   (right_d),
        .hit_in  (hit[gi]),
        .hit_out (hit[gi+1]),
        .data    (cdata[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Response for this request, queued for the output side.
  assign rsp_in.ok        = ok;
  assign rsp_in.count     = RSP_CNT_W'(count_next);
  assign rsp_in.empty_res = count_next == '0;

  deq_rbuf u_rbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_ready  (buf_ready),
    .in_data   (rsp_in),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (rsp_out)
  );

  assign rsp.ok        = rsp_out.ok;
  assign rsp.count     = rsp_out.count;
  assign rsp.empty_res = rsp_out.empty_res;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the deque with erase of first match: a directed
// table, then random requests, each response checked against a shadow deque.
// ----------------------------------------------------------------------------
module testbench;
  import deq_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RST_CYCLES   = 7;
  localparam int N_RANDOM     = 400;
  localparam int PRESSURE_AT  = 120;     // random request where the response side chokes
  localparam int HOLD_CYCLES  = 60;      // length of that choke
  localparam int BURST_LEN    = 40;      // gapless requests offered during the choke
  localparam int DRAIN_CYCLES = 20;      // settle time once nothing is outstanding
  localparam int LIMIT_CYCLES = 200_000;
  localparam int MAX_REPORTS  = 10;

  // Codes outside op_t: the block must refuse them and report its count.
  localparam logic [OP_W-1:0] OP_RSVD_A = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_B = 3'd7;

  localparam rsp_t NO_RSP = '0;

  // One row of the directed table. When fixed_rsp is set, rsp is the response
  // typed in by hand; otherwise the shadow deque supplies it. A row is issued
  // reps times, its value stepping by one each time.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;
    logic [7:0]        reps;
    logic              fixed_rsp;
    rsp_t              rsp;
  } plan_row_t;

  localparam int N_PLAN = 23;

  //            op             value         reps   fix   ok    count empty
  plan_row_t plan [N_PLAN] = '{
    // everything refused on an empty deque, odd code included
    {OP_POP_FRONT,  32'h0000_0000, 8'd1,  1'b1, 1'b0, 5'd0,  1'b1},
    {OP_POP_BACK,   32'h0000_0000, 8'd1,  1'b1, 1'b0, 5'd0,  1'b1},
    {OP_ERASE,      32'h0000_0000, 8'd1,  1'b1, 1'b0, 5'd0,  1'b1},
    {OP_CLEAR,      32'h0000_0000, 8'd1,  1'b1, 1'b0, 5'd0,  1'b1},
    {OP_RSVD_A,     32'h0000_0000, 8'd1,  1'b1, 1'b0, 5'd0,  1'b1},
    // value extremes at both ends: 0, min, max, all ones
    {OP_PUSH_BACK,  32'h7FFF_FFFF, 8'd1,  1'b1, 1'b1, 5'd1,  1'b0},
    {OP_PUSH_FRONT, 32'h8000_0000, 8'd1,  1'b1, 1'b1, 5'd2,  1'b0},
    {OP_PUSH_BACK,  32'hFFFF_FFFF, 8'd1,  1'b1, 1'b1, 5'd3,  1'b0},
    {OP_PUSH_FRONT, 32'h0000_0000, 8'd1,  1'b1, 1'b1, 5'd4,  1'b0},
    {OP_ERASE,      32'h0000_0005, 8'd1,  1'b1, 1'b0, 5'd4,  1'b0},   // no match
    {OP_ERASE,      32'hFFFF_FFFF, 8'd1,  1'b0, NO_RSP},              // hit at the back
    {OP_ERASE,      32'h0000_0000, 8'd1,  1'b0, NO_RSP},              // hit at the front
    {OP_RSVD_B,     32'hFFFF_FFFF, 8'd1,  1'b1, 1'b0, 5'd2,  1'b0},
    {OP_POP_FRONT,  32'h0000_0000, 8'd1,  1'b0, NO_RSP},
    {OP_POP_BACK,   32'h0000_0000, 8'd1,  1'b0, NO_RSP},
    // fill to the brim, with one value present twice
    {OP_PUSH_BACK,  32'h0000_0100, 8'd14, 1'b0, NO_RSP},
    {OP_PUSH_FRONT, 32'h0000_0105, 8'd1,  1'b0, NO_RSP},
    {OP_PUSH_BACK,  32'h55AA_55AA, 8'd1,  1'b0, NO_RSP},
    {OP_PUSH_FRONT, 32'h0000_0001, 8'd1,  1'b1, 1'b0, 5'd16, 1'b0},   // full
    {OP_PUSH_BACK,  32'h0000_0002, 8'd1,  1'b1, 1'b0, 5'd16, 1'b0},   // full
    // duplicates go front first, the gap closing each time
    {OP_ERASE,      32'h0000_0105, 8'd1,  1'b0, NO_RSP},
    {OP_ERASE,      32'h0000_0105, 8'd1,  1'b0, NO_RSP},
    {OP_CLEAR,      32'h0000_0000, 8'd1,  1'b1, 1'b1, 5'd0,  1'b1}
  };

  logic [DATA_W-1:0] corner_vals [4] = '{32'h8000_0000, 32'h7FFF_FFFF,
                                         32'hFFFF_FFFF, 32'h0000_0000};

  logic clk;
  logic rst;

  deq_req_if req_ch ();
  deq_rsp_if rsp_ch ();

  deque_with_erase_first_match_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow of the deque contents, front at index 0, and the responses still
  // owed by the block, oldest first.
  logic [DATA_W-1:0] shadow [$];
  rsp_t              pending_rsp [$];

  int  mismatch_cnt  = 0;
  int  request_cnt   = 0;
  int  full_refusals = 0;
  int  empty_refusals = 0;
  int  erase_misses  = 0;
  int  odd_codes     = 0;
  int  burst_left    = 0;    // requests still to be offered with no gaps
  bit  quiet_sender  = 1'b0; // stretch with no request gaps
  bit  hold_rsp      = 1'b0; // asks the response side to choke
  int  cycle_cnt     = 0;

  // Applies one request to the shadow deque and returns the response the
  // block owes for it.
  function automatic rsp_t deque_apply(input logic [OP_W-1:0] op,
                                       input logic [DATA_W-1:0] v);
    rsp_t r;
    int   hit;
    int   i;
    r   = NO_RSP;
    hit = -1;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow.size() >= DEPTH_DEF) begin
          full_refusals++;
        end else begin
          if (op == OP_PUSH_FRONT) shadow.insert(0, v);
          else shadow.insert(shadow.size(), v);
          r.ok = 1'b1;
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_CLEAR: begin
        if (shadow.size() == 0) begin
          empty_refusals++;
        end else begin
          if (op == OP_POP_FRONT) shadow.delete(0);
          else if (op == OP_POP_BACK) shadow.delete(shadow.size() - 1);
          else shadow.delete();
          r.ok = 1'b1;
        end
      end
      OP_ERASE: begin
        // first match from the front; later entries close the gap
        for (i = 0; i < shadow.size(); i++) begin
          if (hit < 0 && shadow[i] == v) hit = i;
        end
        if (shadow.size() == 0) begin
          empty_refusals++;
        end else if (hit < 0) begin
          erase_misses++;
        end else begin
          shadow.delete(hit);
          r.ok = 1'b1;
        end
      end
      default: begin
        odd_codes++;
      end
    endcase
    r.count     = RSP_CNT_W'(shadow.size());
    r.empty_res = (shadow.size() == 0);
    return r;
  endfunction

  function automatic int sender_gap();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    // keep offering while the response side is asked to choke
    if (hold_rsp) return 0;
    if (quiet_sender) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one request and holds it until the block takes it. Called at a
  // rising edge; valid is dropped only when a gap follows, so a back-to-back
  // request never sees valid fall and rise in one step.
  task automatic issue_request(input logic [OP_W-1:0]   op,
                               input logic [DATA_W-1:0] v,
                               input logic              fixed_rsp,
                               input rsp_t              hand_rsp);
    int   gap;
    rsp_t modeled;
    gap = sender_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.value     <= v;
    do @(posedge clk); while (!req_ch.ready);
    // accepted at this edge: the shadow moves on and the response is owed
    modeled = deque_apply(op, v);
    pending_rsp.insert(pending_rsp.size(), fixed_rsp ? hand_rsp : modeled);
    request_cnt++;
  endtask

  function automatic void note_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, what);
  endfunction

  // Response checker: every accepted response against the oldest one owed.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        note_mismatch($sformatf("response ok=%0b count=%0d empty=%0b with none owed",
                                rsp_ch.ok, rsp_ch.count, rsp_ch.empty_res));
      end else begin
        want = pending_rsp[0];
        pending_rsp.delete(0);
        if (rsp_ch.ok !== want.ok || rsp_ch.count !== want.count ||
            rsp_ch.empty_res !== want.empty_res) begin
          note_mismatch($sformatf("exp ok=%0b count=%0d empty=%0b got ok=%0b count=%0d empty=%0b",
                                  want.ok, want.count, want.empty_res,
                                  rsp_ch.ok, rsp_ch.count, rsp_ch.empty_res));
        end
      end
    end
  end

  // Response pacing: ready runs of random length, mostly short stalls and a
  // few long ones. On request it chokes for HOLD_CYCLES, counted here, while
  // the sender keeps offering so the buffer fills and the input stalls.
  initial begin : rsp_pacing
    int run;
    int stall;
    int held;
    int roll;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_rsp = 1'b0;
      end else begin
        run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        rsp_ch.ready <= 1'b1;
        repeat (run) @(posedge clk);
        roll = $urandom_range(0, 99);
        if (roll < 40) stall = 0;
        else if (roll < 90) stall = $urandom_range(1, 3);
        else stall = $urandom_range(8, 30);
        if (stall > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("deque_with_erase_first_match_top verification failed");
    $finish;
  end

  // Main sequence: reset, directed table, random requests, drain, verdict.
  initial begin : stimulus
    int                r;
    int                k;
    int                n;
    int                roll;
    int                directed_cnt;
    bit                filling;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] v;

    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_PUSH_FRONT;
    req_ch.value     <= '0;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed table: empty refusals, extremes, odd codes, full, duplicates.
    for (r = 0; r < N_PLAN; r++) begin
      for (k = 0; k < plan[r].reps; k++) begin
        issue_request(plan[r].op, plan[r].value + k, plan[r].fixed_rsp, plan[r].rsp);
      end
    end
    directed_cnt = request_cnt;

    // Random part. The deque swings between filling and draining so that
    // both the full and the empty edge are hit many times; erase mostly
    // targets a value that is present, and a small value pool breeds
    // duplicates.
    filling = 1'b1;
    for (n = 0; n < N_RANDOM; n++) begin
      if (n == PRESSURE_AT) begin
        hold_rsp   = 1'b1;
        burst_left = BURST_LEN;
      end
      if (n % 40 == 0) quiet_sender = ($urandom_range(0, 2) == 0);
      if (shadow.size() == DEPTH_DEF && $urandom_range(0, 2) == 0) filling = 1'b0;
      else if (shadow.size() == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;

      roll = $urandom_range(0, 99);
      if (roll < 3) op = $urandom_range(0, 1) ? OP_RSVD_A : OP_RSVD_B;
      else if (roll < 5) op = OP_CLEAR;
      else if (roll < (filling ? 65 : 25))
        op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      else if (roll < (filling ? 80 : 75))
        op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
      else op = OP_ERASE;

      roll = $urandom_range(0, 99);
      if (op == OP_ERASE && shadow.size() != 0 && roll < 70)
        v = shadow[$urandom_range(0, shadow.size() - 1)];
      else if (roll < 40) v = $urandom_range(0, 7);
      else if (roll < 50) v = corner_vals[$urandom_range(0, 3)];
      else v = $urandom;

      issue_request(op, v, 1'b0, NO_RSP);
    end
    req_ch.valid <= 1'b0;

    // Drain: wait for every owed response, then watch for strays.
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests (%0d directed) with random gaps and a %0d-cycle output choke.",
             request_cnt, directed_cnt, HOLD_CYCLES);
    $display("Refused: %0d pushes at full, %0d on empty, %0d erase misses, %0d odd codes.",
             full_refusals, empty_refusals, erase_misses, odd_codes);
    if (mismatch_cnt == 0) begin
      $display("deque_with_erase_first_match_top verification clean");
    end else begin
      $display("%0d mismatches in total", mismatch_cnt);
      $display("deque_with_erase_first_match_top verification failed");
    end
    $finish;
  end

endmodule
